// ===== sv/frlc_pkg.sv =====
// ----------------------------------------------------------------------------
// frlc_pkg
// Types, constants and the byte classifier for the FASTA record length counter.
// ----------------------------------------------------------------------------
`default_nettype none

package frlc_pkg;

    localparam int LENGTH_BITS_DEFAULT = 40;

    localparam int BYTE_W         = 8;
    localparam int NAME_LIMIT_W   = 12;
    localparam int RECORD_LIMIT_W = 16;
    localparam int RECORD_COUNT_W = 17;
    localparam int RECORD_NUM_W   = 16;
    localparam int FIELD_W        = 40;
    localparam int STATUS_W       = 2;
    localparam int CFG_INDEX_W    = 1;
    localparam int CFG_DATA_W     = 16;
    localparam int S_TDATA_W      = 8;
    // record_number, total_length, unambiguous_length, invalid_count
    localparam int M_TDATA_W      = RECORD_NUM_W + 3 * FIELD_W;

    localparam int TOTAL_LSB = RECORD_NUM_W;
    localparam int UNAMB_LSB = TOTAL_LSB + FIELD_W;
    localparam int INVAL_LSB = UNAMB_LSB + FIELD_W;

    localparam logic [NAME_LIMIT_W-1:0]   NAME_LIMIT_RESET   = 12'd256;
    localparam logic [RECORD_LIMIT_W-1:0] RECORD_LIMIT_RESET = 16'd1024;
    localparam logic [RECORD_COUNT_W-1:0] RECORD_COUNT_MAX   = '1;

    localparam logic [BYTE_W-1:0] CHAR_MARKER  = 8'h3E;  // '>'
    localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;

    localparam logic [CFG_INDEX_W-1:0] REG_NAME_LIMIT   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_RECORD_LIMIT = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_RECORD       = 2'd0,
        STATUS_NAME_LONG    = 2'd1,
        STATUS_TOO_MANY     = 2'd2,
        STATUS_UNTERMINATED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        BASE_SKIP    = 2'd0,
        BASE_BOTH    = 2'd1,
        BASE_TOTAL   = 2'd2,
        BASE_INVALID = 2'd3
    } base_class_t;

    // Nucleotides and IUPAC ambiguity codes count in both lengths, N/n only in
    // the total; line ends and NUL are dropped.
    function automatic base_class_t base_class(input logic [BYTE_W-1:0] b);
        base_class_t cls;
        if (b inside {"A", "C", "G", "T", "a", "c", "g", "t",
                      "R", "Y", "K", "M", "S", "W", "B", "D", "H", "V",
                      "r", "y", "k", "m", "s", "w", "b", "d", "h", "v"}) begin
            cls = BASE_BOTH;
        end else if (b inside {"N", "n"}) begin
            cls = BASE_TOTAL;
        end else if (b inside {8'h0A, 8'h0D, 8'h00}) begin
            cls = BASE_SKIP;
        end else begin
            cls = BASE_INVALID;
        end
        return cls;
    endfunction

endpackage

`default_nettype wire

// ===== sv/fasta_record_length_counter_core.sv =====
// ----------------------------------------------------------------------------
// fasta_record_length_counter_core
// Per-record length, unambiguous length and invalid-byte counts of a FASTA
// byte stream, one result word per record or per error.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  ---------+-----------+------------------------------------------------------
//  s_*      | in        | tdata: in_byte; tlast: end_of_input
//  m_*      | out       | tdata: record_number, three lengths; tuser: status
//  cfg_*    | in        | register write: name_limit, record_limit
//
//  One byte is taken every cycle while s_tready is high; the state is updated
//  in the cycle it is accepted and a result word appears on m_* in the next cycle.
//  The output register lets s_tready stay high while a word waits, as long as
//  m_tready takes it in the same cycle; a stalled full output stops the input.
//  Synchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module fasta_record_length_counter_core
    import frlc_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
    input  wire                      aclk,
    input  wire                      aresetn,

    input  wire                      s_tvalid,
    output logic                     s_tready,
    input  wire  [S_TDATA_W-1:0]     s_tdata,   // [7:0] in_byte
    input  wire                      s_tlast,   // end_of_input

    output logic                     m_tvalid,
    input  wire                      m_tready,
    output logic [M_TDATA_W-1:0]     m_tdata,   // [15:0] record_number,
                                                // [55:16] total_length,
                                                // [95:56] unambiguous_length,
                                                // [135:96] invalid_count
    output logic [STATUS_W-1:0]      m_tuser,   // [1:0] status

    input  wire                      cfg_we,
    input  wire  [CFG_INDEX_W-1:0]   cfg_index,
    input  wire  [CFG_DATA_W-1:0]    cfg_wdata
);

    // configuration
    logic [NAME_LIMIT_W-1:0]   name_limit_reg;
    logic [RECORD_LIMIT_W-1:0] record_limit_reg;

    // stream state
    logic                      at_line_start_reg, at_line_start_next;
    logic                      in_header_reg,     in_header_next;
    logic [NAME_LIMIT_W-1:0]   header_bytes_reg,  header_bytes_next;
    logic                      record_open_reg,   record_open_next;
    logic [RECORD_COUNT_W-1:0] record_count_reg,  record_count_next;
    logic [LENGTH_BITS-1:0]    total_reg,         total_next;
    logic [LENGTH_BITS-1:0]    unamb_reg,         unamb_next;
    logic [LENGTH_BITS-1:0]    invalid_reg,       invalid_next;
    logic                      halted_reg,        halted_next;

    // output register
    logic                      m_tvalid_reg,      m_tvalid_next;
    logic [M_TDATA_W-1:0]      m_tdata_reg,       m_tdata_next;
    status_t                   m_tuser_reg,       m_tuser_next;

    logic                      s_fire;
    logic [BYTE_W-1:0]         in_byte;
    logic                      end_of_input;
    logic                      emit;
    status_t                   emit_status;
    logic                      emit_counts;
    base_class_t               cls;
    logic [63:0]               total_wide, unamb_wide, invalid_wide;
    logic [RECORD_NUM_W-1:0]   record_index;
    logic [RECORD_COUNT_W-1:0] record_index_full;

    assign s_tready     = !m_tvalid_reg || m_tready;
    assign s_fire       = s_tvalid && s_tready;
    assign in_byte      = s_tdata[BYTE_W-1:0];
    assign end_of_input = s_tlast;
    assign cls          = base_class(in_byte);

    function automatic logic [LENGTH_BITS-1:0] sat_inc(input logic [LENGTH_BITS-1:0] v);
        return (&v) ? v : v + LENGTH_BITS'(1);
    endfunction

    always_comb begin
        at_line_start_next = at_line_start_reg;
        in_header_next     = in_header_reg;
        header_bytes_next  = header_bytes_reg;
        record_open_next   = record_open_reg;
        record_count_next  = record_count_reg;
        total_next         = total_reg;
        unamb_next         = unamb_reg;
        invalid_next       = invalid_reg;
        halted_next        = halted_reg;
        emit               = 1'b0;
        emit_status        = STATUS_RECORD;
        emit_counts        = 1'b0;

        if (end_of_input) begin
            if (!halted_reg) begin
                if (in_header_reg) begin
                    emit        = 1'b1;
                    emit_status = STATUS_UNTERMINATED;
                end else if (record_open_reg) begin
                    emit        = 1'b1;
                    emit_counts = 1'b1;
                end
            end
            at_line_start_next = 1'b1;
            in_header_next     = 1'b0;
            header_bytes_next  = '0;
            record_open_next   = 1'b0;
            record_count_next  = '0;
            total_next         = '0;
            unamb_next         = '0;
            invalid_next       = '0;
            halted_next        = 1'b0;
        end else if (halted_reg) begin
            // dropped until the end word
        end else if (in_header_reg) begin
            if (header_bytes_reg >= name_limit_reg) begin
                emit        = 1'b1;
                emit_status = STATUS_NAME_LONG;
                halted_next = 1'b1;
            end else begin
                header_bytes_next = header_bytes_reg + NAME_LIMIT_W'(1);
                if (in_byte == CHAR_NEWLINE) begin
                    in_header_next     = 1'b0;
                    at_line_start_next = 1'b1;
                    if (record_count_reg > {1'b0, record_limit_reg}) begin
                        emit        = 1'b1;
                        emit_status = STATUS_TOO_MANY;
                        halted_next = 1'b1;
                    end
                end
            end
        end else if (at_line_start_reg && in_byte == CHAR_MARKER) begin
            if (record_open_reg) begin
                emit        = 1'b1;
                emit_counts = 1'b1;
            end
            if (record_count_reg != RECORD_COUNT_MAX) begin
                record_count_next = record_count_reg + RECORD_COUNT_W'(1);
            end
            record_open_next   = 1'b1;
            total_next         = '0;
            unamb_next         = '0;
            invalid_next       = '0;
            in_header_next     = 1'b1;
            header_bytes_next  = '0;
            at_line_start_next = 1'b0;
        end else begin
            at_line_start_next = (in_byte == CHAR_NEWLINE);
            if (record_open_reg) begin
                case (cls)
                    BASE_BOTH: begin
                        total_next = sat_inc(total_reg);
                        unamb_next = sat_inc(unamb_reg);
                    end
                    BASE_TOTAL: begin
                        total_next = sat_inc(total_reg);
                    end
                    BASE_INVALID: begin
                        total_next   = sat_inc(total_reg);
                        invalid_next = sat_inc(invalid_reg);
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // result word built from the counts as they stand before this byte
    assign total_wide        = 64'(total_reg);
    assign unamb_wide        = 64'(unamb_reg);
    assign invalid_wide      = 64'(invalid_reg);
    assign record_index_full = record_count_reg - RECORD_COUNT_W'(1);
    assign record_index      = record_index_full[RECORD_NUM_W-1:0];

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (s_fire && emit) begin
            m_tvalid_next = 1'b1;
            m_tuser_next  = emit_status;
            m_tdata_next  = {
                emit_counts ? invalid_wide[FIELD_W-1:0] : {FIELD_W{1'b0}},
                emit_counts ? unamb_wide[FIELD_W-1:0]   : {FIELD_W{1'b0}},
                emit_counts ? total_wide[FIELD_W-1:0]   : {FIELD_W{1'b0}},
                record_index
            };
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            name_limit_reg    <= NAME_LIMIT_RESET;
            record_limit_reg  <= RECORD_LIMIT_RESET;
            at_line_start_reg <= 1'b1;
            in_header_reg     <= 1'b0;
            header_bytes_reg  <= '0;
            record_open_reg   <= 1'b0;
            record_count_reg  <= '0;
            total_reg         <= '0;
            unamb_reg         <= '0;
            invalid_reg       <= '0;
            halted_reg        <= 1'b0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_NAME_LIMIT:   name_limit_reg   <= cfg_wdata[NAME_LIMIT_W-1:0];
                    REG_RECORD_LIMIT: record_limit_reg <= cfg_wdata[RECORD_LIMIT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (s_fire) begin
                at_line_start_reg <= at_line_start_next;
                in_header_reg     <= in_header_next;
                header_bytes_reg  <= header_bytes_next;
                record_open_reg   <= record_open_next;
                record_count_reg  <= record_count_next;
                total_reg         <= total_next;
                unamb_reg         <= unamb_next;
                invalid_reg       <= invalid_next;
                halted_reg        <= halted_next;
            end
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

// ===== sv/frlc_checker.sv =====
// ----------------------------------------------------------------------------
// frlc_checker
// Port-level checks for the FASTA record length counter, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module frlc_checker
    import frlc_pkg::*;
(
    input wire                   aclk,
    input wire                   aresetn,
    input wire                   s_tready,
    input wire                   m_tvalid,
    input wire                   m_tready,
    input wire [M_TDATA_W-1:0]   m_tdata,
    input wire [STATUS_W-1:0]    m_tuser
);

    logic [FIELD_W-1:0] total_f, unamb_f, inval_f;

    assign total_f = m_tdata[TOTAL_LSB +: FIELD_W];
    assign unamb_f = m_tdata[UNAMB_LSB +: FIELD_W];
    assign inval_f = m_tdata[INVAL_LSB +: FIELD_W];

    // a stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // input never blocked while the output register is empty
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // error words carry no counts
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != STATUS_RECORD |->
            total_f == '0 && unamb_f == '0 && inval_f == '0)
        else $error("error word with nonzero counts");

    // both partial counts are bounded by the total
    a_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STATUS_RECORD |->
            unamb_f <= total_f && inval_f <= total_f)
        else $error("partial count exceeds total");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid after reset");

endmodule

bind fasta_record_length_counter_core frlc_checker u_frlc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
